>>> hdl/cprd_pkg.sv
// ----------------------------------------------------------------------------
// cprd_pkg
// Shared constants for the primary ray direction block: defaults, register
// indexes, reset values and fixed-point widths.
// ----------------------------------------------------------------------------
package cprd_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;
  localparam int RATIO_W    = 24;
  localparam int ROW_W      = 63;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ASPECT_RATIO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_FOV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW2  = 3'd6;

  localparam int                 WIDTH_RST  = 640;
  localparam int                 HEIGHT_RST = 480;
  localparam logic [RATIO_W-1:0] ASPECT_RST = 24'd87381;
  localparam logic [RATIO_W-1:0] TAN_RST    = 24'd65536;

  // Q.16 helpers
  localparam int          Q16      = 16;
  localparam int          K_W      = 32;
  localparam logic [31:0] K_RST    = 32'd87381;
  localparam int          HALF_Q16 = 32768;
  localparam int          SAT_BIT  = 62;
  localparam int          MAG1_W   = SAT_BIT - Q16 + 1;

  // normalized component width: largest magnitude lands in [2^29, 2^30)
  localparam int NORM_C_W = 30;

endpackage

>>> hdl/cprd_div.sv
// ----------------------------------------------------------------------------
// cprd_div
// Pipelined restoring divider, one quotient bit per stage. The part of the
// numerator above the quotient bits must be below the divisor.
// ----------------------------------------------------------------------------
module cprd_div #(
  parameter int N_W = 31,
  parameter int D_W = 14,
  parameter int Q_W = 30
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic [Q_W-1:0] quo_o
);

  logic [D_W-1:0] rem_q [Q_W];
  logic [D_W-1:0] den_q [Q_W];
  logic [Q_W-1:0] low_q [Q_W];
  logic [Q_W-1:0] quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W-1:0] rem_s;
    logic [D_W-1:0] den_s;
    logic [Q_W-1:0] low_s;
    logic [Q_W-1:0] quo_s;
    logic [D_W:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_s = D_W'(num_i >> Q_W);
      assign den_s = den_i;
      assign low_s = num_i[Q_W-1:0];
      assign quo_s = '0;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign den_s = den_q[k-1];
      assign low_s = low_q[k-1];
      assign quo_s = quo_q[k-1];
    end

    assign trial = {rem_s, low_s[Q_W-1]};
    assign ge    = trial >= {1'b0, den_s};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? D_W'(trial - {1'b0, den_s}) : D_W'(trial);
        den_q[k] <= den_s;
        low_q[k] <= low_s << 1;
        quo_q[k] <= {quo_s[Q_W-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

>>> hdl/cprd_norm.sv
// ----------------------------------------------------------------------------
// cprd_norm
// Pipelined 3-vector normalizer: common shift of the magnitudes, sum of
// squares, bit-serial square root, rounded divide by the length.
// ----------------------------------------------------------------------------
module cprd_norm #(
  parameter int MAG_W  = 47,
  parameter int FRAC_W = 18
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [MAG_W-1:0]         mag_i [3],
  input  logic [2:0]               neg_i,
  output logic signed [FRAC_W+1:0] dir_o [3]
);

  localparam int C_W    = cprd_pkg::NORM_C_W;
  localparam int SH_W   = MAG_W + C_W - 1;
  localparam int P_W    = $clog2(MAG_W);
  localparam int SQ_W   = 2 * C_W;
  localparam int SUM_W  = 2 * C_W + 2;
  localparam int LEN_W  = C_W + 1;
  localparam int SQRT_N = LEN_W;
  localparam int N_W    = C_W + FRAC_W + 2;
  localparam int Q_W    = FRAC_W + 1;
  localparam int D_W    = LEN_W + 1;
  localparam int CD_DLY = SQRT_N + 2;
  localparam int SG_DLY = SQRT_N + 2 + Q_W;
  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_W;

  // stage 1: max
  logic [MAG_W-1:0] mag1_q [3];
  logic [2:0]       neg1_q;
  logic [MAG_W-1:0] m1_q;
  logic [MAG_W-1:0] m1_d;

  always_comb begin
    m1_d = mag_i[0];
    if (mag_i[1] > m1_d) m1_d = mag_i[1];
    if (mag_i[2] > m1_d) m1_d = mag_i[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= mag_i;
      neg1_q <= neg_i;
      m1_q   <= m1_d;
    end
  end

  // stage 2: leading one of the max
  logic [MAG_W-1:0] mag2_q [3];
  logic [2:0]       neg2_q;
  logic [P_W-1:0]   p2_q;
  logic             zero2_q;
  logic [P_W-1:0]   p2_d;

  always_comb begin
    p2_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m1_q[i]) p2_d = P_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      p2_q    <= p2_d;
      zero2_q <= (m1_q == '0);
    end
  end

  // stage 3: common shift
  logic [C_W-1:0] c3_q [3];
  logic [2:0]     neg3_q;
  logic           zero3_q;
  logic [C_W-1:0] c3_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c3_d[i] = C_W'((SH_W'(mag2_q[i]) << (C_W - 1)) >> p2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q    <= c3_d;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // stages 4, 5: squares and their sum
  logic [SQ_W-1:0]  sq4_q [3];
  logic [SUM_W-1:0] sum5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= SQ_W'(c3_q[i]) * SQ_W'(c3_q[i]);
      end
      sum5_q <= SUM_W'(sq4_q[0]) + SUM_W'(sq4_q[1]) + SUM_W'(sq4_q[2]);
    end
  end

  // square root, one result bit per stage
  logic [SUM_W-1:0] sv_q [SQRT_N];
  logic [SUM_W-1:0] sr_q [SQRT_N];

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_N - 1 - k));
    logic [SUM_W-1:0] v_s;
    logic [SUM_W-1:0] r_s;
    logic [SUM_W-1:0] tr;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_s = sum5_q;
      assign r_s = '0;
    end else begin : g_next
      assign v_s = sv_q[k-1];
      assign r_s = sr_q[k-1];
    end

    assign tr = r_s + BIT;
    assign ge = v_s >= tr;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sv_q[k] <= ge ? v_s - tr : v_s;
        sr_q[k] <= ge ? (r_s >> 1) + BIT : r_s >> 1;
      end
    end
  end

  // side delay lines
  logic [C_W-1:0] cd_q [CD_DLY][3];
  logic [2:0]     ngd_q [SG_DLY];
  logic           zd_q [SG_DLY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cd_q[0]  <= c3_q;
      ngd_q[0] <= neg3_q;
      zd_q[0]  <= zero3_q;
      for (int j = 1; j < CD_DLY; j++) cd_q[j] <= cd_q[j-1];
      for (int j = 1; j < SG_DLY; j++) begin
        ngd_q[j] <= ngd_q[j-1];
        zd_q[j]  <= zd_q[j-1];
      end
    end
  end

  // rounded divide by the length
  logic [LEN_W-1:0] len;
  logic [Q_W-1:0]   quo [3];

  assign len = LEN_W'(sr_q[SQRT_N-1]);

  for (genvar i = 0; i < 3; i++) begin : g_div
    cprd_div #(
      .N_W(N_W),
      .D_W(D_W),
      .Q_W(Q_W)
    ) u_div (
      .clk_i(clk_i),
      .en_i (en_i),
      .num_i(N_W'({cd_q[CD_DLY-1][i], Q_W'(0)}) + N_W'(len)),
      .den_i({len, 1'b0}),
      .quo_o(quo[i])
    );
  end

  // final: clamp, sign, zero vector
  logic signed [FRAC_W+1:0] dir_q [3];
  logic signed [FRAC_W+1:0] dir_d [3];
  logic [Q_W-1:0]           qc;

  always_comb begin
    qc = '0;
    for (int i = 0; i < 3; i++) begin
      qc       = (quo[i] > ONE) ? ONE : quo[i];
      dir_d[i] = $signed((FRAC_W + 2)'(qc));
      if (ngd_q[SG_DLY-1][i]) dir_d[i] = -dir_d[i];
      if (zd_q[SG_DLY-1]) dir_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dir_q <= dir_d;
  end

  assign dir_o = dir_q;

endmodule

>>> hdl/camera_primary_ray_direction.sv
// ----------------------------------------------------------------------------
// camera_primary_ray_direction
// Pinhole camera primary ray direction: screen vector from pixel center,
// normalize, camera matrix, normalize again.
// The pipeline runs through the pixel dividers, two square-root chains and
// two divides by the length.
// Throughput: one item per cycle; all stages advance together unless the
// output register holds an item that is stalled.
// Reset: configuration returns to 640x480, aspect 4:3, tan 1.0, identity
// matrix; the pipeline empties.
// ----------------------------------------------------------------------------
module camera_primary_ray_direction #(
  parameter int COORD_BITS = cprd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = cprd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cprd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cprd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [COORD_BITS-1:0]               pixel_x_i,
  input  logic [COORD_BITS-1:0]               pixel_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [FRAC_BITS+1:0]         dir_x_o,
  output logic signed [FRAC_BITS+1:0]         dir_y_o,
  output logic signed [FRAC_BITS+1:0]         dir_z_o
);

  localparam int SIZE_W  = COORD_BITS + 1;
  localparam int SGN_W   = COORD_BITS + 3;
  localparam int NUM_W   = COORD_BITS + 19;
  localparam int DEN_W   = COORD_BITS + 2;
  localparam int QD_W    = COORD_BITS + 18;
  localparam int K_W     = cprd_pkg::K_W;
  localparam int R_W     = cprd_pkg::RATIO_W;
  localparam int PX_W    = QD_W + K_W;
  localparam int PY_W    = QD_W + R_W;
  localparam int EX_W    = (PX_W > 63) ? PX_W : 63;
  localparam int EY_W    = (PY_W > 63) ? PY_W : 63;
  localparam int MAG1_W  = cprd_pkg::MAG1_W;
  localparam int MAT_W   = FRAC_BITS + 3;
  localparam int DIR_W   = FRAC_BITS + 2;
  localparam int PM_W    = MAT_W + DIR_W;
  localparam int T_W     = 2 * FRAC_BITS + 4;
  localparam int MAG2_W  = 2 * FRAC_BITS + 3;
  localparam int ROW_W   = cprd_pkg::ROW_W;
  localparam int NORM_L  = FRAC_BITS + 38;
  localparam int TOT_L   = QD_W + 4 + 2 * NORM_L;
  localparam logic [EX_W-1:0] SAT_X = EX_W'(1) << cprd_pkg::SAT_BIT;
  localparam logic [EY_W-1:0] SAT_Y = EY_W'(1) << cprd_pkg::SAT_BIT;
  localparam int ONE = 1 << FRAC_BITS;

  // configuration registers
  logic [SIZE_W-1:0] width_q, height_q;
  logic [R_W-1:0]    aspect_q, tan_q;
  logic [ROW_W-1:0]  row_q [3];
  logic [K_W-1:0]    k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(cprd_pkg::WIDTH_RST);
      height_q <= SIZE_W'(cprd_pkg::HEIGHT_RST);
      aspect_q <= cprd_pkg::ASPECT_RST;
      tan_q    <= cprd_pkg::TAN_RST;
      row_q[0] <= ROW_W'(1) << FRAC_BITS;
      row_q[1] <= ROW_W'(1) << (MAT_W + FRAC_BITS);
      row_q[2] <= ROW_W'(1) << (2 * MAT_W + FRAC_BITS);
      k_q      <= cprd_pkg::K_RST;
    end else begin
      k_q <= K_W'(((2 * R_W)'(aspect_q) * (2 * R_W)'(tan_q)
                   + (2 * R_W)'(cprd_pkg::HALF_Q16)) >> cprd_pkg::Q16);
      if (cfg_we_i) begin
        case (cfg_index_i)
          cprd_pkg::REG_IMAGE_WIDTH:  width_q  <= SIZE_W'(cfg_data_i);
          cprd_pkg::REG_IMAGE_HEIGHT: height_q <= SIZE_W'(cfg_data_i);
          cprd_pkg::REG_ASPECT_RATIO: aspect_q <= R_W'(cfg_data_i);
          cprd_pkg::REG_TAN_HALF_FOV: tan_q    <= R_W'(cfg_data_i);
          cprd_pkg::REG_MATRIX_ROW0:  row_q[0] <= ROW_W'(cfg_data_i);
          cprd_pkg::REG_MATRIX_ROW1:  row_q[1] <= ROW_W'(cfg_data_i);
          cprd_pkg::REG_MATRIX_ROW2:  row_q[2] <= ROW_W'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // global advance
  logic             en;
  logic [TOT_L-1:0] vld_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[TOT_L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT_L-2:0], in_valid_i};
    end
  end

  // screen offsets from pixel center
  logic [SIZE_W-1:0]       w_eff, h_eff;
  logic signed [SGN_W-1:0] nx, ny;
  logic [SIZE_W-1:0]       ax, ay;

  assign w_eff = (width_q == '0) ? SIZE_W'(1) : width_q;
  assign h_eff = (height_q == '0) ? SIZE_W'(1) : height_q;
  assign nx = $signed({2'b00, pixel_x_i, 1'b1}) - $signed({2'b00, w_eff});
  assign ny = $signed({2'b00, h_eff}) - $signed({2'b00, pixel_y_i, 1'b1});
  assign ax = SIZE_W'((nx < 0) ? -nx : nx);
  assign ay = SIZE_W'((ny < 0) ? -ny : ny);

  logic [QD_W-1:0] mx, my;

  cprd_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QD_W)) u_div_x (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(NUM_W'({ax, 17'b0}) + NUM_W'(w_eff)),
    .den_i({w_eff, 1'b0}),
    .quo_o(mx)
  );

  cprd_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(QD_W)) u_div_y (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(NUM_W'({ay, 17'b0}) + NUM_W'(h_eff)),
    .den_i({h_eff, 1'b0}),
    .quo_o(my)
  );

  logic [1:0] sgn_q [QD_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sgn_q[0] <= {ny < 0, nx < 0};
      for (int j = 1; j < QD_W; j++) sgn_q[j] <= sgn_q[j-1];
    end
  end

  // scale by aspect*tan and tan, then clamp and round
  logic [PX_W-1:0]   px_q;
  logic [PY_W-1:0]   py_q;
  logic [1:0]        sgm_q;
  logic [MAG1_W-1:0] mag1_q [3];
  logic [2:0]        ngr_q;
  logic [EX_W-1:0]   sx;
  logic [EY_W-1:0]   sy;

  assign sx = (EX_W'(px_q) > SAT_X) ? SAT_X : EX_W'(px_q);
  assign sy = (EY_W'(py_q) > SAT_Y) ? SAT_Y : EY_W'(py_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q      <= PX_W'(mx) * PX_W'(k_q);
      py_q      <= PY_W'(my) * PY_W'(tan_q);
      sgm_q     <= sgn_q[QD_W-1];
      mag1_q[0] <= MAG1_W'((sx + EX_W'(cprd_pkg::HALF_Q16)) >> cprd_pkg::Q16);
      mag1_q[1] <= MAG1_W'((sy + EY_W'(cprd_pkg::HALF_Q16)) >> cprd_pkg::Q16);
      mag1_q[2] <= MAG1_W'(1) << cprd_pkg::Q16;
      ngr_q     <= {1'b1, sgm_q};
    end
  end

  logic signed [DIR_W-1:0] n1 [3];

  cprd_norm #(.MAG_W(MAG1_W), .FRAC_W(FRAC_BITS)) u_norm_cam (
    .clk_i(clk_i),
    .en_i (en),
    .mag_i(mag1_q),
    .neg_i(ngr_q),
    .dir_o(n1)
  );

  // camera matrix
  logic signed [MAT_W-1:0] mel [3][3];
  logic signed [PM_W-1:0]  mp_q [3][3];
  logic signed [T_W-1:0]   t_q [3];
  logic signed [T_W-1:0]   t_d [3];
  logic signed [PM_W-1:0]  rnd;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mel[r][c] = $signed(MAT_W'((3 * MAT_W)'(row_q[r]) >> (c * MAT_W)));
      end
    end
  end

  always_comb begin
    rnd = '0;
    for (int r = 0; r < 3; r++) begin
      t_d[r] = '0;
      for (int c = 0; c < 3; c++) begin
        rnd    = mp_q[r][c] + (mp_q[r][c][PM_W-1] ? $signed(PM_W'(3)) : $signed(PM_W'(0)));
        t_d[r] = t_d[r] + T_W'(rnd >>> 2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mp_q[r][c] <= mel[r][c] * n1[c];
        end
      end
      t_q <= t_d;
    end
  end

  logic [MAG2_W-1:0] mag2 [3];
  logic [2:0]        neg2;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      neg2[r] = t_q[r] < 0;
      mag2[r] = MAG2_W'(neg2[r] ? -t_q[r] : t_q[r]);
    end
  end

  logic signed [DIR_W-1:0] n2 [3];

  cprd_norm #(.MAG_W(MAG2_W), .FRAC_W(FRAC_BITS)) u_norm_world (
    .clk_i(clk_i),
    .en_i (en),
    .mag_i(mag2),
    .neg_i(neg2),
    .dir_o(n2)
  );

  assign dir_x_o = n2[0];
  assign dir_y_o = n2[1];
  assign dir_z_o = n2[2];

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dir_x_o <= ONE && dir_x_o >= -ONE && dir_y_o <= ONE &&
                     dir_y_o >= -ONE && dir_z_o <= ONE && dir_z_o >= -ONE))
    else $error("direction component beyond unit range");

endmodule
